@@ sv/kcr_pkg.sv @@
// Shared types, key codes and the combination table of the key combination remapper.
`default_nettype none

package kcr_pkg;

  localparam int unsigned MAP_ENTRIES     = 20;
  localparam int unsigned TRACKED_KEYS    = 11;
  localparam int unsigned MAX_RESULTS     = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CODE_W    = 10;
  localparam int unsigned VAL_W     = 2;
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned EVT_IDX_W = $clog2(MAX_RESULTS);

  typedef logic [CODE_W-1:0] kcr_code_t;
  typedef logic [VAL_W-1:0]  kcr_val_t;

  localparam kcr_val_t VAL_RELEASE = 2'd0;
  localparam kcr_val_t VAL_PRESS   = 2'd1;
  localparam kcr_val_t VAL_REPEAT  = 2'd2;
  localparam kcr_val_t VAL_INVALID = 2'd3;

  localparam kcr_code_t KC_NONE   = 10'd0;
  localparam kcr_code_t KC_E      = 10'd18;
  localparam kcr_code_t KC_P      = 10'd25;
  localparam kcr_code_t KC_LCTRL  = 10'd29;
  localparam kcr_code_t KC_A      = 10'd30;
  localparam kcr_code_t KC_F      = 10'd33;
  localparam kcr_code_t KC_V      = 10'd47;
  localparam kcr_code_t KC_B      = 10'd48;
  localparam kcr_code_t KC_N      = 10'd49;
  localparam kcr_code_t KC_LALT   = 10'd56;
  localparam kcr_code_t KC_RCTRL  = 10'd97;
  localparam kcr_code_t KC_RALT   = 10'd100;
  localparam kcr_code_t KC_HOMEK  = 10'd102;
  localparam kcr_code_t KC_UP     = 10'd103;
  localparam kcr_code_t KC_PGUP   = 10'd104;
  localparam kcr_code_t KC_LARROW = 10'd105;
  localparam kcr_code_t KC_RARROW = 10'd106;
  localparam kcr_code_t KC_ENDK   = 10'd107;
  localparam kcr_code_t KC_DN     = 10'd108;
  localparam kcr_code_t KC_PGDN   = 10'd109;

  typedef struct packed {
    kcr_code_t mod_src;
    kcr_code_t key_src;
    kcr_code_t mod_dst;
    kcr_code_t key_dst;
  } kcr_combo_t;

  localparam kcr_combo_t COMBO_TABLE [MAP_ENTRIES] = '{
    '{KC_RCTRL, KC_F, KC_NONE,  KC_RARROW},
    '{KC_LCTRL, KC_F, KC_NONE,  KC_RARROW},
    '{KC_RCTRL, KC_B, KC_NONE,  KC_LARROW},
    '{KC_LCTRL, KC_B, KC_NONE,  KC_LARROW},
    '{KC_RCTRL, KC_P, KC_NONE,  KC_UP},
    '{KC_LCTRL, KC_P, KC_NONE,  KC_UP},
    '{KC_RCTRL, KC_N, KC_NONE,  KC_DN},
    '{KC_LCTRL, KC_N, KC_NONE,  KC_DN},
    '{KC_RCTRL, KC_A, KC_NONE,  KC_HOMEK},
    '{KC_LCTRL, KC_A, KC_NONE,  KC_HOMEK},
    '{KC_RCTRL, KC_E, KC_NONE,  KC_ENDK},
    '{KC_LCTRL, KC_E, KC_NONE,  KC_ENDK},
    '{KC_RALT,  KC_F, KC_RCTRL, KC_RARROW},
    '{KC_LALT,  KC_F, KC_LCTRL, KC_RARROW},
    '{KC_RALT,  KC_B, KC_RCTRL, KC_LARROW},
    '{KC_LALT,  KC_B, KC_LCTRL, KC_LARROW},
    '{KC_RALT,  KC_V, KC_NONE,  KC_PGUP},
    '{KC_LALT,  KC_V, KC_NONE,  KC_PGUP},
    '{KC_RCTRL, KC_V, KC_NONE,  KC_PGDN},
    '{KC_LCTRL, KC_V, KC_NONE,  KC_PGDN}
  };

  localparam kcr_code_t TRACKED_CODES [TRACKED_KEYS] = '{
    KC_LCTRL, KC_RCTRL, KC_LALT, KC_RALT, KC_P, KC_F,
    KC_B, KC_N, KC_V, KC_A, KC_E
  };

  typedef struct packed {
    kcr_code_t code;
    kcr_val_t  value;
  } kcr_evt_t;

  typedef struct packed {
    kcr_evt_t [MAX_RESULTS-1:0] evts;
    logic [RUN_CNT_W-1:0]       count;
  } kcr_run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kcr_q_stat_t;

endpackage

`default_nettype wire

@@ sv/kcr_if.sv @@
// Valid/ready channel interfaces for key events in and substitute events out.
`default_nettype none

interface kcr_in_if;
  import kcr_pkg::*;
  logic      valid;
  logic      ready;
  kcr_code_t key_code;
  kcr_val_t  key_value;
  logic      remap_enable;

  modport source (output valid, output key_code, output key_value,
                  output remap_enable, input ready);
  modport sink (input valid, input key_code, input key_value,
                input remap_enable, output ready);
endinterface

interface kcr_out_if;
  import kcr_pkg::*;
  logic      valid;
  logic      ready;
  kcr_code_t out_code;
  kcr_val_t  out_value;
  logic      last_of_run;

  modport source (output valid, output out_code, output out_value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_code, input out_value,
                input last_of_run, output ready);
endinterface

`default_nettype wire

@@ sv/kcr_front.sv @@
// Front end: tracks key states, matches combinations and builds the run of output events.
`default_nettype none

module kcr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  kcr_in_if.sink                    in_ch,
  input  wire kcr_pkg::kcr_q_stat_t q_stat,
  output logic                      push,
  output kcr_pkg::kcr_run_t         run
);
  import kcr_pkg::*;

  kcr_val_t [TRACKED_KEYS-1:0] state_r;
  kcr_val_t [TRACKED_KEYS-1:0] state_nxt;
  kcr_val_t [MAP_ENTRIES-1:0]  mod_st;
  kcr_val_t [MAP_ENTRIES-1:0]  key_st;
  logic [MAP_ENTRIES-1:0]      key_act;
  logic [MAP_ENTRIES-1:0]      mod_act;
  logic [MAP_ENTRIES-1:0]      sel_act;
  logic                        accept;
  logic                        use_key;
  logic                        use_mod;
  logic                        held;
  kcr_combo_t                  sel;
  kcr_val_t                    partner_st;
  kcr_code_t                   code;
  kcr_val_t                    value;

  function automatic logic only_one(logic [MAP_ENTRIES-1:0] v);
    return (v != '0) && ((v & (v - 1'b1)) == '0);
  endfunction

  function automatic kcr_run_t run_add(kcr_run_t r, kcr_code_t c, kcr_val_t v);
    kcr_run_t o;
    o = r;
    o.evts[r.count[EVT_IDX_W-1:0]] = '{code: c, value: v};
    o.count = r.count + RUN_CNT_W'(1);
    return o;
  endfunction

  assign code        = in_ch.key_code;
  assign value       = in_ch.key_value;
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (run.count != '0);

  always_comb begin
    for (int i = 0; i < TRACKED_KEYS; i++) begin
      state_nxt[i] = (code == TRACKED_CODES[i]) ? value : state_r[i];
    end
  end

  // Matching sees the state after this event has been recorded.
  always_comb begin
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      mod_st[j] = VAL_INVALID;
      key_st[j] = VAL_INVALID;
      for (int i = 0; i < TRACKED_KEYS; i++) begin
        if (TRACKED_CODES[i] == COMBO_TABLE[j].mod_src) begin
          mod_st[j] = state_nxt[i];
        end
        if (TRACKED_CODES[i] == COMBO_TABLE[j].key_src) begin
          key_st[j] = state_nxt[i];
        end
      end
      key_act[j] = (COMBO_TABLE[j].key_src == code) && (mod_st[j] != VAL_RELEASE);
      mod_act[j] = (COMBO_TABLE[j].mod_src == code) && (key_st[j] != VAL_RELEASE);
    end
  end

  assign use_key = in_ch.remap_enable && only_one(key_act);
  assign use_mod = in_ch.remap_enable && !use_key && only_one(mod_act);
  assign sel_act = use_key ? key_act : mod_act;

  always_comb begin
    sel        = '0;
    partner_st = '0;
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      if (sel_act[j]) begin
        sel        = sel | COMBO_TABLE[j];
        partner_st = partner_st | (use_key ? mod_st[j] : key_st[j]);
      end
    end
  end

  assign held = (partner_st == VAL_PRESS) || (partner_st == VAL_REPEAT);

  always_comb begin
    run = '0;
    if (use_key) begin
      if (partner_st == VAL_RELEASE && value != VAL_INVALID) begin
        run = run_add(run, code, value);
      end else if (held && value == VAL_PRESS) begin
        run = run_add(run, sel.mod_src, VAL_RELEASE);
        if (sel.mod_dst != KC_NONE) begin
          run = run_add(run, sel.mod_dst, VAL_PRESS);
        end
        run = run_add(run, sel.key_dst, VAL_PRESS);
      end else if (held && value == VAL_REPEAT) begin
        run = run_add(run, sel.key_dst, VAL_REPEAT);
      end else if (held && value == VAL_RELEASE) begin
        run = run_add(run, sel.key_dst, VAL_RELEASE);
        if (sel.mod_dst != KC_NONE) begin
          run = run_add(run, sel.mod_dst, VAL_RELEASE);
        end
        run = run_add(run, sel.mod_src, VAL_PRESS);
      end
    end else if (use_mod) begin
      if (partner_st == VAL_RELEASE && value != VAL_INVALID) begin
        run = run_add(run, code, value);
      end else if (held && value == VAL_PRESS) begin
        run = run_add(run, sel.mod_src, VAL_RELEASE);
        run = run_add(run, sel.key_src, VAL_RELEASE);
        if (sel.mod_dst != KC_NONE) begin
          run = run_add(run, sel.mod_dst, VAL_PRESS);
        end
        run = run_add(run, sel.key_dst, VAL_PRESS);
      end else if (held && value == VAL_RELEASE) begin
        run = run_add(run, code, VAL_RELEASE);
        if (sel.mod_dst != KC_NONE) begin
          run = run_add(run, sel.mod_dst, VAL_RELEASE);
        end
        run = run_add(run, sel.key_dst, VAL_RELEASE);
        run = run_add(run, sel.key_src, VAL_PRESS);
      end
    end else begin
      run = run_add(run, code, value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/kcr_run_queue.sv @@
// Small FIFO of event runs between the front end and the back end.
`default_nettype none

module kcr_run_queue #(
  parameter int unsigned DEPTH = kcr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire kcr_pkg::kcr_run_t push_data,
  input  wire logic              pop,
  output kcr_pkg::kcr_run_t      pop_data,
  output kcr_pkg::kcr_q_stat_t   stat
);
  import kcr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  kcr_run_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/kcr_back.sv @@
// Back end: steps through the head run and drives one event per transfer into the output register.
`default_nettype none

module kcr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kcr_pkg::kcr_run_t    head,
  input  wire kcr_pkg::kcr_q_stat_t q_stat,
  output logic                      pop,
  kcr_out_if.source                 out_ch
);
  import kcr_pkg::*;

  logic [EVT_IDX_W-1:0] evt_idx_r;
  logic [EVT_IDX_W-1:0] evt_idx_nxt;
  logic                 out_valid_r;
  kcr_code_t            out_code_r;
  kcr_val_t             out_value_r;
  logic                 out_last_r;
  logic                 load;
  logic                 emit;
  logic                 cur_last;
  kcr_evt_t             cur_evt;

  assign load     = !out_valid_r || out_ch.ready;
  assign emit     = load && !q_stat.empty;
  assign cur_evt  = head.evts[evt_idx_r];
  assign cur_last = ((RUN_CNT_W'(evt_idx_r) + RUN_CNT_W'(1)) == head.count);
  assign pop      = emit && cur_last;

  always_comb begin
    evt_idx_nxt = evt_idx_r;
    if (emit) begin
      evt_idx_nxt = cur_last ? '0 : evt_idx_r + EVT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      evt_idx_r <= evt_idx_nxt;
      if (load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r  <= cur_evt.code;
      out_value_r <= cur_evt.value;
      out_last_r  <= cur_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_code    = out_code_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

`default_nettype wire

@@ sv/key_combo_remapper.sv @@
// Key combination remapper: key events in, remapped or passed-through key events out.
// The front end takes one key event per cycle while the run queue has room, records the
// key state, matches the fixed combination table and turns the event into a run of zero
// to four output events. The back end drives one event per cycle through its output
// register while the output is not stalled, so an event that yields n outputs holds the
// output port for n transfers and the sustained rate is set by that single output port;
// events that yield nothing are not queued and take no output transfer. The first output
// of a run is written into the run queue and then into the output register before it is
// valid; last_of_run marks the final event of each run.
`default_nettype none

module key_combo_remapper #(
  parameter int unsigned QUEUE_DEPTH = kcr_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  kcr_in_if.sink    in_ch,
  kcr_out_if.source out_ch
);
  import kcr_pkg::*;

  logic        q_push;
  logic        q_pop;
  kcr_run_t    new_run;
  kcr_run_t    head_run;
  kcr_q_stat_t q_stat;

  kcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (q_push),
    .run    (new_run)
  );

  kcr_run_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (new_run),
    .pop       (q_pop),
    .pop_data  (head_run),
    .stat      (q_stat)
  );

  kcr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_run),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  a_run_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (new_run.count != '0) && (new_run.count <= RUN_CNT_W'(MAX_RESULTS)))
    else $error("run written to the queue has no events or too many");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid && out_ch.last_of_run)
    else $error("run retired without its last event shown");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !q_pop)
    else $error("run retired while the output transfer is stalled");

endmodule

`default_nettype wire

@@ dv/key_combo_remapper_tb.sv @@
// Self-checking testbench for key_combo_remapper: directed and random key traffic.
`timescale 1ns / 100ps

module key_combo_remapper_tb;
  import kcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    kcr_code_t code;
    kcr_val_t  value;
    logic      last;
  } key_event_t;

  class remap_scoreboard;
    kcr_val_t   held_values [TRACKED_KEYS];
    key_event_t due_events [$];
    key_event_t run_events [$];
    int         errors;

    function new();
      for (int i = 0; i < TRACKED_KEYS; i++) held_values[i] = VAL_RELEASE;
      errors = 0;
    endfunction

    // A code that is not tracked reads as the invalid value.
    function kcr_val_t key_state(kcr_code_t code);
      for (int i = 0; i < TRACKED_KEYS; i++) begin
        if (TRACKED_CODES[i] == code) return held_values[i];
      end
      return VAL_INVALID;
    endfunction

    function int active_entry(kcr_code_t code, bit by_mod);
      int hits;
      int idx;
      kcr_code_t own_code;
      kcr_code_t partner;
      hits = 0;
      idx = -1;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        own_code = by_mod ? COMBO_TABLE[i].mod_src : COMBO_TABLE[i].key_src;
        partner = by_mod ? COMBO_TABLE[i].key_src : COMBO_TABLE[i].mod_src;
        if (own_code == code && key_state(partner) != VAL_RELEASE) begin
          hits++;
          idx = i;
        end
      end
      return (hits == 1) ? idx : -1;
    endfunction

    function void emit_event(kcr_code_t code, kcr_val_t value);
      run_events.push_back('{code: code, value: value, last: 1'b0});
    endfunction

    function void accept_key_event(kcr_code_t code, kcr_val_t value, logic enable);
      int key_hit;
      int mod_hit;
      kcr_combo_t entry;
      kcr_val_t partner_state;
      bit held;
      run_events.delete();
      for (int i = 0; i < TRACKED_KEYS; i++) begin
        if (TRACKED_CODES[i] == code) held_values[i] = value;
      end
      key_hit = enable ? active_entry(code, 1'b0) : -1;
      mod_hit = (enable && key_hit < 0) ? active_entry(code, 1'b1) : -1;
      if (key_hit >= 0) begin
        entry = COMBO_TABLE[key_hit];
        partner_state = key_state(entry.mod_src);
        held = (partner_state == VAL_PRESS) || (partner_state == VAL_REPEAT);
        if (partner_state == VAL_RELEASE && value != VAL_INVALID) begin
          emit_event(code, value);
        end else if (held && value == VAL_PRESS) begin
          emit_event(entry.mod_src, VAL_RELEASE);
          if (entry.mod_dst != KC_NONE) emit_event(entry.mod_dst, VAL_PRESS);
          emit_event(entry.key_dst, VAL_PRESS);
        end else if (held && value == VAL_REPEAT) begin
          emit_event(entry.key_dst, VAL_REPEAT);
        end else if (held && value == VAL_RELEASE) begin
          emit_event(entry.key_dst, VAL_RELEASE);
          if (entry.mod_dst != KC_NONE) emit_event(entry.mod_dst, VAL_RELEASE);
          emit_event(entry.mod_src, VAL_PRESS);
        end
      end else if (mod_hit >= 0) begin
        entry = COMBO_TABLE[mod_hit];
        partner_state = key_state(entry.key_src);
        held = (partner_state == VAL_PRESS) || (partner_state == VAL_REPEAT);
        if (partner_state == VAL_RELEASE && value != VAL_INVALID) begin
          emit_event(code, value);
        end else if (held && value == VAL_PRESS) begin
          emit_event(entry.mod_src, VAL_RELEASE);
          emit_event(entry.key_src, VAL_RELEASE);
          if (entry.mod_dst != KC_NONE) emit_event(entry.mod_dst, VAL_PRESS);
          emit_event(entry.key_dst, VAL_PRESS);
        end else if (held && value == VAL_RELEASE) begin
          emit_event(code, VAL_RELEASE);
          if (entry.mod_dst != KC_NONE) emit_event(entry.mod_dst, VAL_RELEASE);
          emit_event(entry.key_dst, VAL_RELEASE);
          emit_event(entry.key_src, VAL_PRESS);
        end
      end else begin
        emit_event(code, value);
      end
      if (run_events.size() > 0) run_events[run_events.size() - 1].last = 1'b1;
      foreach (run_events[i]) due_events.push_back(run_events[i]);
    endfunction

    function void check_emitted_event(kcr_code_t code, kcr_val_t value, logic last);
      key_event_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected transfer, got code %0d value %0d last %0b",
                 $time, code, value, last);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (want.code !== code || want.value !== value || want.last !== last) begin
        $display("%0t: mismatch, exp code %0d value %0d last %0b, got %0d %0d %0b",
                 $time, want.code, want.value, want.last, code, value, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   events_sent;
  int   idle_cycles;

  remap_scoreboard ledger = new();

  kcr_in_if  in_ch ();
  kcr_out_if out_ch ();

  key_combo_remapper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        ledger.accept_key_event(in_ch.key_code, in_ch.key_value, in_ch.remap_enable);
      end
      if (out_ch.valid && out_ch.ready) begin
        ledger.check_emitted_event(out_ch.out_code, out_ch.out_value, out_ch.last_of_run);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("key_combo_remapper regression: fail");
      $finish;
    end
  end

  // Valid stays high from one transfer to the next unless an idle cycle is drawn.
  task automatic drive_key_event(kcr_code_t code, kcr_val_t value, logic enable);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key_code <= code;
    in_ch.key_value <= value;
    in_ch.remap_enable <= enable;
    do @(posedge clk); while (!in_ch.ready);
    events_sent++;
  endtask

  task automatic run_directed();
    drive_key_event(10'd0, VAL_PRESS, 1'b1);
    drive_key_event(10'd767, VAL_REPEAT, 1'b1);
    drive_key_event(10'd512, VAL_INVALID, 1'b1);
    drive_key_event(KC_LCTRL, VAL_PRESS, 1'b1);
    drive_key_event(KC_F, VAL_PRESS, 1'b1);
    drive_key_event(KC_F, VAL_REPEAT, 1'b1);
    drive_key_event(KC_F, VAL_RELEASE, 1'b1);
    drive_key_event(KC_LALT, VAL_PRESS, 1'b1);
    // Two combinations are active for B here, so it passes through.
    drive_key_event(KC_B, VAL_PRESS, 1'b1);
    drive_key_event(KC_LCTRL, VAL_RELEASE, 1'b1);
    drive_key_event(KC_B, VAL_REPEAT, 1'b1);
    drive_key_event(KC_LALT, VAL_REPEAT, 1'b1);
    drive_key_event(KC_LALT, VAL_PRESS, 1'b1);
    drive_key_event(KC_LALT, VAL_RELEASE, 1'b1);
    drive_key_event(KC_B, VAL_RELEASE, 1'b1);
    drive_key_event(KC_LCTRL, VAL_INVALID, 1'b1);
    drive_key_event(KC_V, VAL_PRESS, 1'b1);
    drive_key_event(KC_V, VAL_INVALID, 1'b1);
    drive_key_event(KC_LCTRL, VAL_PRESS, 1'b1);
    drive_key_event(KC_LCTRL, VAL_RELEASE, 1'b1);
    drive_key_event(KC_V, VAL_RELEASE, 1'b1);
    drive_key_event(KC_RALT, VAL_PRESS, 1'b1);
    drive_key_event(KC_F, VAL_PRESS, 1'b0);
    drive_key_event(KC_F, VAL_RELEASE, 1'b0);
    drive_key_event(KC_F, VAL_PRESS, 1'b1);
    drive_key_event(KC_F, VAL_RELEASE, 1'b1);
    drive_key_event(KC_RALT, VAL_RELEASE, 1'b1);
  endtask

  // One modifier and key pair from the table, held, repeated and released.
  task automatic play_combination();
    kcr_combo_t entry;
    int repeats;
    entry = COMBO_TABLE[$urandom_range(MAP_ENTRIES - 1)];
    drive_key_event(entry.mod_src, VAL_PRESS, $urandom_range(9) != 0);
    if ($urandom_range(3) == 0) drive_key_event(entry.mod_src, VAL_REPEAT, $urandom_range(9) != 0);
    drive_key_event(entry.key_src, VAL_PRESS, $urandom_range(9) != 0);
    repeats = $urandom_range(2);
    repeat (repeats) drive_key_event(entry.key_src, VAL_REPEAT, $urandom_range(9) != 0);
    if ($urandom_range(1) == 0) begin
      drive_key_event(entry.key_src, VAL_RELEASE, $urandom_range(9) != 0);
      drive_key_event(entry.mod_src, VAL_RELEASE, $urandom_range(9) != 0);
    end else begin
      drive_key_event(entry.mod_src, VAL_RELEASE, $urandom_range(9) != 0);
      drive_key_event(entry.key_src, VAL_RELEASE, $urandom_range(9) != 0);
    end
  endtask

  task automatic play_noise();
    kcr_code_t code;
    kcr_val_t value;
    if ($urandom_range(1) == 0) begin
      code = kcr_code_t'($urandom_range(767));
    end else begin
      code = TRACKED_CODES[$urandom_range(TRACKED_KEYS - 1)];
    end
    value = ($urandom_range(15) == 0) ? VAL_INVALID : kcr_val_t'($urandom_range(2));
    drive_key_event(code, value, $urandom_range(3) != 0);
  endtask

  initial begin
    int target;
    clk = 1'b0;
    rst_n = 1'b0;
    idle_cycles = 0;
    events_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.key_code = KC_NONE;
    in_ch.key_value = VAL_RELEASE;
    in_ch.remap_enable = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      target = events_sent + ITEMS_PER_PHASE;
      while (events_sent < target) begin
        if ($urandom_range(4) == 0) play_noise();
        else play_combination();
      end
    end
    in_ch.valid <= 1'b0;

    while (ledger.due_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.errors == 0 && ledger.due_events.size() == 0) begin
      $display("key_combo_remapper regression: pass");
    end else begin
      $display("key_combo_remapper regression: fail");
    end
    $finish;
  end

endmodule

@@ key_combo_remapper.f @@
sv/kcr_pkg.sv
sv/kcr_if.sv
sv/kcr_front.sv
sv/kcr_run_queue.sv
sv/kcr_back.sv
sv/key_combo_remapper.sv
dv/key_combo_remapper_tb.sv
